// File: rtl/atan2_rational_approx_macros.svh
// Assertion macros used by the checker file of the angle block.
// Needs a clk and a rst signal in the scope where a macro is used.
`ifndef ATAN2_RATIONAL_APPROX_MACROS_SVH
`define ATAN2_RATIONAL_APPROX_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define AT2_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high.
`define AT2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define AT2_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/at2_pkg.sv
// Package of the angle block: constants, item flags and the pi helpers.
// Used by every file in rtl but the macro header; depends on nothing.
package at2_pkg;

  localparam int COORD_WIDTH_DEF     = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  // Magnitudes are brought down to this many bits before the products.
  localparam int MAG_W  = 16;
  localparam int PROD_W = 2 * MAG_W;
  localparam int DEN_W  = PROD_W + 5;
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic first;
    logic t_neg;
    logic x_neg;
    logic y_neg;
  } meta_t;

  function automatic logic [63:0] pi_val(input int frac);
    pi_val = (PI_Q62 + (64'd1 << (61 - frac))) >> (62 - frac);
  endfunction

  function automatic logic [63:0] half_pi_val(input int frac);
    half_pi_val = (PI_Q62 + (64'd1 << (62 - frac))) >> (63 - frac);
  endfunction

endpackage

// File: rtl/at2_coord_if.sv
// Input channel of the angle block: a y,x coordinate pair per beat.
// Depends on at2_pkg for its default width.
interface at2_coord_if #(
  parameter int COORD_WIDTH = at2_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic signed [COORD_WIDTH-1:0] x_coord;

  modport source (output valid, output y_coord, output x_coord, input ready);
  modport sink (input valid, input y_coord, input x_coord, output ready);
endinterface

// File: rtl/at2_angle_if.sv
// Output channel of the angle block: one angle per beat.
// Depends on at2_pkg for its default width.
interface at2_angle_if #(
  parameter int ANGLE_FRAC_BITS = at2_pkg::ANGLE_FRAC_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [ANGLE_FRAC_BITS+2:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

// File: rtl/at2_div_cell.sv
// One cell of the division chain: develops one quotient bit per item.
// Depends on at2_pkg for the item flags.
module at2_div_cell #(
  parameter int QW = at2_pkg::ANGLE_FRAC_BITS_DEF + 1,
  parameter int DW = at2_pkg::DEN_W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  at2_pkg::meta_t  in_meta,
  input  logic [DW-1:0]   in_rem,
  input  logic [DW-1:0]   in_den,
  input  logic [QW-1:0]   in_quo,
  output logic            out_valid,
  input  logic            out_ready,
  output at2_pkg::meta_t  out_meta,
  output logic [DW-1:0]   out_rem,
  output logic [DW-1:0]   out_den,
  output logic [QW-1:0]   out_quo
);
  logic          valid;
  logic          load;
  logic [DW:0]   rem2;
  logic [DW:0]   diff;
  logic          take;

  assign in_ready = !valid || out_ready;
  assign load     = in_valid && in_ready;
  assign rem2     = {in_rem, 1'b0};
  assign diff     = rem2 - {1'b0, in_den};
  assign take     = rem2 >= {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_meta <= in_meta;
      out_den  <= in_den;
      out_rem  <= take ? diff[DW-1:0] : rem2[DW-1:0];
      out_quo  <= {in_quo[QW-2:0], take};
    end
  end

  assign out_valid = valid;
endmodule

// File: rtl/atan2_rational_approx.sv
// Top level of the angle block: front stages, division cell chain, output stage.
// Depends on at2_pkg, at2_coord_if, at2_angle_if and at2_div_cell.
//
//   Channel  Dir  Payload                     Handshake
//   coord    in   y_coord, x_coord (signed)   valid / ready
//   result   out  angle, signed Q2.13         valid / ready
//
// One pair enters per cycle while the output is not stalled. The pipeline is four
// front stages, one division cell per quotient bit (ANGLE_FRAC_BITS + 1 cells)
// and the output register. Each stage holds its own valid bit, so a stalled
// output backs up stage by stage and bubbles close up.
// Reset clears all valid bits.
module atan2_rational_approx #(
  parameter int COORD_WIDTH     = at2_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = at2_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  at2_coord_if.sink   coord,
  at2_angle_if.source result
);
  localparam int CW   = COORD_WIDTH;
  localparam int F    = ANGLE_FRAC_BITS;
  localparam int QW   = F + 1;
  localparam int AW   = F + 3;
  localparam int MW   = at2_pkg::MAG_W;
  localparam int PW   = at2_pkg::PROD_W;
  localparam int DW   = at2_pkg::DEN_W;
  localparam int SHW  = $clog2(CW + 1);
  localparam int NC   = QW;
  localparam logic [63:0] PI_FULL   = at2_pkg::pi_val(F);
  localparam logic [63:0] HALF_FULL = at2_pkg::half_pi_val(F);

  // Stage 0: magnitudes and flags.
  logic                 v0, rdy0;
  logic [CW-1:0]        ymag, xmag;
  at2_pkg::meta_t       meta0;
  // Stage 1: magnitudes scaled to MW bits.
  logic                 v1, rdy1;
  logic [MW-1:0]        sa, sb;
  at2_pkg::meta_t       meta1;
  // Stage 2: products.
  logic                 v2, rdy2;
  logic [PW-1:0]        pab, paa, pbb;
  at2_pkg::meta_t       meta2;
  // Stage 3: numerator and denominator.
  logic                 v3, rdy3;
  logic [DW-1:0]        num, den;
  at2_pkg::meta_t       meta3;

  logic [CW-1:0]        ymag_next, xmag_next, mmax;
  at2_pkg::meta_t       meta0_next;
  logic [SHW-1:0]       hb, sh;
  logic [DW-1:0]        num_next, den_next;

  // Division chain: the ratio is below one, so only fraction bits are formed.
  logic           cell_v   [NC+1];
  logic           cell_rdy [NC+1];
  at2_pkg::meta_t cell_meta[NC+1];
  logic [DW-1:0]  cell_rem [NC+1];
  logic [DW-1:0]  cell_den [NC+1];
  logic [QW-1:0]  cell_quo [NC+1];

  assign ymag_next = coord.y_coord[CW-1] ? CW'(-coord.y_coord) : CW'(coord.y_coord);
  assign xmag_next = coord.x_coord[CW-1] ? CW'(-coord.x_coord) : CW'(coord.x_coord);

  always_comb begin
    meta0_next.x_neg  = coord.x_coord[CW-1];
    meta0_next.y_neg  = coord.y_coord[CW-1];
    meta0_next.x_zero = (xmag_next == '0);
    meta0_next.y_zero = (ymag_next == '0);
    meta0_next.first  = ymag_next < xmag_next;
    meta0_next.t_neg  = (ymag_next != '0) && (coord.x_coord[CW-1] != coord.y_coord[CW-1]);
  end

  assign rdy0        = !v0 || rdy1;
  assign coord.ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= coord.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (coord.valid && rdy0) begin
      ymag  <= ymag_next;
      xmag  <= xmag_next;
      meta0 <= meta0_next;
    end
  end

  // The larger magnitude sets a common right shift that leaves it in MW bits.
  assign mmax = (ymag > xmag) ? ymag : xmag;

  always_comb begin
    hb = '0;
    for (int i = 0; i < CW; i++) begin
      if (mmax[i]) begin
        hb = SHW'(i);
      end
    end
    sh = (hb > SHW'(MW - 1)) ? hb - SHW'(MW - 1) : '0;
  end

  assign rdy1 = !v1 || rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (v0 && rdy1) begin
      sa    <= MW'(ymag >> sh);
      sb    <= MW'(xmag >> sh);
      meta1 <= meta0;
    end
  end

  assign rdy2 = !v2 || rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      pab   <= sa * sb;
      paa   <= sa * sa;
      pbb   <= sb * sb;
      meta2 <= meta1;
    end
  end

  // 25p = 16p + 8p + p and 7p = 8p - p, with 0.28 taken as 7/25.
  always_comb begin
    logic [DW-1:0] big, minor;
    big      = meta2.first ? DW'(pbb) : DW'(paa);
    minor    = meta2.first ? DW'(paa) : DW'(pbb);
    num_next = (DW'(pab) << 4) + (DW'(pab) << 3) + DW'(pab);
    den_next = (big << 4) + (big << 3) + big + (minor << 3) - minor;
  end

  assign rdy3 = !v3 || cell_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      num   <= num_next;
      den   <= den_next;
      meta3 <= meta2;
    end
  end

  assign cell_v[0]    = v3;
  assign cell_meta[0] = meta3;
  assign cell_rem[0]  = num;
  assign cell_den[0]  = den;
  assign cell_quo[0]  = '0;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    at2_div_cell #(.QW(QW), .DW(DW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_v[g]),
      .in_ready  (cell_rdy[g]),
      .in_meta   (cell_meta[g]),
      .in_rem    (cell_rem[g]),
      .in_den    (cell_den[g]),
      .in_quo    (cell_quo[g]),
      .out_valid (cell_v[g+1]),
      .out_ready (cell_rdy[g+1]),
      .out_meta  (cell_meta[g+1]),
      .out_rem   (cell_rem[g+1]),
      .out_den   (cell_den[g+1]),
      .out_quo   (cell_quo[g+1])
    );
  end

  // Output stage: rounding, sign and quadrant correction.
  logic                 vo;
  logic signed [AW-1:0] angle_q;
  logic signed [AW-1:0] angle_next;
  logic [QW:0]          qsum;
  logic signed [AW-1:0] qmag, tval, pi_s, half_s;
  at2_pkg::meta_t       mo;

  assign cell_rdy[NC] = !vo || result.ready;
  assign mo           = cell_meta[NC];
  assign qsum         = {1'b0, cell_quo[NC]} + (QW+1)'(1);
  assign qmag         = AW'(qsum[QW:1]);
  assign tval         = mo.t_neg ? -qmag : qmag;
  assign pi_s         = AW'(PI_FULL);
  assign half_s       = AW'(HALF_FULL);

  always_comb begin
    if (mo.x_zero) begin
      if (mo.y_zero) begin
        angle_next = '0;
      end else begin
        angle_next = mo.y_neg ? -half_s : half_s;
      end
    end else if (mo.first) begin
      if (!mo.x_neg) begin
        angle_next = tval;
      end else begin
        angle_next = mo.y_neg ? tval - pi_s : tval + pi_s;
      end
    end else begin
      angle_next = mo.y_neg ? half_s - tval - pi_s : half_s - tval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (cell_rdy[NC]) begin
      vo <= cell_v[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (cell_v[NC] && cell_rdy[NC]) begin
      angle_q <= angle_next;
    end
  end

  assign result.valid = vo;
  assign result.angle = angle_q;
endmodule

// File: rtl/at2_checker.sv
// Port-level checker for the angle block, bound to its top level.
// Depends on at2_pkg and atan2_rational_approx_macros.svh.
`include "atan2_rational_approx_macros.svh"

module at2_checker #(
  parameter int ANGLE_FRAC_BITS = at2_pkg::ANGLE_FRAC_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ANGLE_FRAC_BITS+2:0] angle
);
  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam logic signed [AW-1:0] PI_S = AW'(at2_pkg::pi_val(ANGLE_FRAC_BITS));

  `AT2_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid, "output valid right after reset")
  `AT2_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(angle), "stalled beat changed")
  `AT2_ASSERT_NOW(a_range, out_valid, (angle <= PI_S) && (angle >= -PI_S), "angle beyond pi")
  `AT2_ASSERT_NOW(a_ready_empty, !out_valid, in_ready, "input stalled while the output is empty")
endmodule

bind atan2_rational_approx at2_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_at2_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (coord.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .angle     (result.angle)
);
